// ===== sv/dtcq_pkg.sv =====
// Shared types and constants of the device type confirmation qualifier.
package dtcq_pkg;

  // Number of controller slots and the index width that they need.
  localparam int SLOTS       = 8;
  localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_FIELD_W = 3;

  // Controller type codes.
  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_PAD2 = 2'd1;
  localparam logic [1:0] TYPE_PAD6 = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Register map, by word index.
  localparam int          ADDR_W       = 4;
  localparam logic [1:0]  REG_UPGRADE  = 2'd0;
  localparam logic [1:0]  REG_DOWNGRADE = 2'd1;
  localparam logic [1:0]  REG_CHANGE   = 2'd2;
  localparam logic [1:0]  REG_TIMEOUT  = 2'd3;

  // Reset values of the registers.
  localparam logic [15:0] UPGRADE_RST   = 16'd3;
  localparam logic [15:0] DOWNGRADE_RST = 16'd3;
  localparam logic [15:0] CHANGE_RST    = 16'd3;
  localparam logic [31:0] TIMEOUT_RST   = 32'd500;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } dtcq_cmd_t;

endpackage

// ===== sv/dtcq_ctrl.sv =====
// Controller of the qualifier: input and output handshakes and sequencing.
module dtcq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output dtcq_pkg::dtcq_cmd_t cmd
);
  import dtcq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  assign in_stall    = (state == ST_EXEC);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.commit  = (state == ST_EXEC) && out_free;

  // Next state and output valid.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next     = ST_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/dtcq_datapath.sv =====
// Datapath of the qualifier: slot state, registers and the update of one slot.
module dtcq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dtcq_pkg::dtcq_cmd_t                 cmd,
  input  logic                                action,
  input  logic [dtcq_pkg::SLOT_FIELD_W-1:0]   slot,
  input  logic [1:0]                          seen_type,
  input  logic                                just_connected,
  input  logic [31:0]                         now_ms,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dtcq_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic [1:0]                          held_type,
  output logic [1:0]                          candidate_type,
  output logic [15:0]                         candidate_count,
  output logic                                type_changed,
  output logic                                released
);
  import dtcq_pkg::*;

  // Configuration registers.
  logic [15:0] upgrade_confirm;
  logic [15:0] downgrade_confirm;
  logic [15:0] change_confirm;
  logic [31:0] absent_timeout_ms;
  logic        cfg_write;
  logic [1:0]  reg_idx;

  // Per-slot state.
  logic [1:0]  stable_store [SLOTS];
  logic [1:0]  cand_store   [SLOTS];
  logic [15:0] count_store  [SLOTS];
  logic [31:0] last_store   [SLOTS];
  logic        seen_store   [SLOTS];

  // Captured item.
  logic                    action_r;
  logic [SLOT_FIELD_W-1:0] slot_r;
  logic [1:0]              obs_r;
  logic                    fresh_r;
  logic [31:0]             now_r;

  // Update of the addressed slot.
  logic [SLOT_IDX_W-1:0] idx;
  logic                  in_range;
  logic [1:0]            cur;
  logic [1:0]            cand;
  logic [15:0]           cnt;
  logic [15:0]           need;
  logic [15:0]           cnt_inc;
  logic [31:0]           elapsed;
  logic                  hold;
  logic [1:0]            stable_next;
  logic [1:0]            cand_next;
  logic [15:0]           count_next;
  logic [31:0]           last_next;
  logic                  seen_next;
  logic                  released_next;

  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      upgrade_confirm   <= UPGRADE_RST;
      downgrade_confirm <= DOWNGRADE_RST;
      change_confirm    <= CHANGE_RST;
      absent_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_UPGRADE:   upgrade_confirm   <= pwdata[15:0];
        REG_DOWNGRADE: downgrade_confirm <= pwdata[15:0];
        REG_CHANGE:    change_confirm    <= pwdata[15:0];
        REG_TIMEOUT:   absent_timeout_ms <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      REG_UPGRADE:   prdata = {16'd0, upgrade_confirm};
      REG_DOWNGRADE: prdata = {16'd0, downgrade_confirm};
      REG_CHANGE:    prdata = {16'd0, change_confirm};
      REG_TIMEOUT:   prdata = absent_timeout_ms;
      default:       prdata = 32'd0;
    endcase
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action;
      slot_r   <= slot;
      obs_r    <= seen_type;
      fresh_r  <= just_connected;
      now_r    <= now_ms;
    end
  end

  // Read of the addressed slot.
  assign in_range = ({1'b0, slot_r} < (SLOT_FIELD_W + 1)'(SLOTS));
  assign idx      = slot_r[SLOT_IDX_W-1:0];
  assign cur      = stable_store[idx];
  assign cand     = cand_store[idx];
  assign cnt      = count_store[idx];
  assign elapsed  = now_r - last_store[idx];
  assign hold     = seen_store[idx] && (elapsed < absent_timeout_ms);
  assign cnt_inc  = (cnt == COUNT_MAX) ? cnt : cnt + 16'd1;

  // Confirmations required for the change at hand.
  always_comb begin
    if (cur == TYPE_PAD2 && obs_r == TYPE_PAD6) begin
      need = upgrade_confirm;
    end else if (cur == TYPE_PAD6 && obs_r == TYPE_PAD2) begin
      need = downgrade_confirm;
    end else begin
      need = change_confirm;
    end
  end

  // New slot entry after an observe or an absent item.
  always_comb begin
    stable_next   = cur;
    cand_next     = cand;
    count_next    = cnt;
    last_next     = last_store[idx];
    seen_next     = seen_store[idx];
    released_next = 1'b0;
    if (!action_r) begin
      last_next = now_r;
      seen_next = 1'b1;
      if (fresh_r || cur == TYPE_NONE || obs_r == cur) begin
        stable_next = obs_r;
        cand_next   = TYPE_NONE;
        count_next  = 16'd0;
      end else begin
        if (cand != obs_r) begin
          cand_next  = obs_r;
          count_next = 16'd1;
        end else begin
          count_next = cnt_inc;
        end
        if (count_next >= need) begin
          stable_next = obs_r;
          cand_next   = TYPE_NONE;
          count_next  = 16'd0;
        end
      end
    end else if (cur != TYPE_NONE && !hold) begin
      stable_next   = TYPE_NONE;
      cand_next     = TYPE_NONE;
      count_next    = 16'd0;
      last_next     = 32'd0;
      seen_next     = 1'b0;
      released_next = 1'b1;
    end
  end

  // Write-back of the slot state; control parts are cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        stable_store[i] <= TYPE_NONE;
        cand_store[i]   <= TYPE_NONE;
        count_store[i]  <= 16'd0;
        seen_store[i]   <= 1'b0;
      end
    end else if (cmd.commit && in_range) begin
      stable_store[idx] <= stable_next;
      cand_store[idx]   <= cand_next;
      count_store[idx]  <= count_next;
      seen_store[idx]   <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && in_range) begin
      last_store[idx] <= last_next;
    end
  end

  // Output register; an out-of-range slot gives an all-zero result.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (in_range) begin
        held_type       <= stable_next;
        candidate_type  <= cand_next;
        candidate_count <= count_next;
        type_changed    <= (stable_next != cur);
        released        <= released_next;
      end else begin
        held_type       <= TYPE_NONE;
        candidate_type  <= TYPE_NONE;
        candidate_count <= 16'd0;
        type_changed    <= 1'b0;
        released        <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/device_type_confirm_qualifier.sv =====
// Top level of the device type confirmation qualifier.
//
// Items arrive on the input channel (in_valid, in_stall) and each gives
// exactly one result on the output channel (out_valid, out_stall). An item
// is taken when valid is high and stall is low. An observe item records the
// slot's time and confirms or adopts the seen type; an absent item releases
// the slot unless it was seen within the timeout.
// An item is captured in the idle state; the exec state reads, updates and
// writes back its slot entry and loads the output register. The result shows
// on the cycle after the load. No new item is taken during the exec state,
// for the single slot read-modify-write. When the receiver stalls, the
// result holds in the output register; one further item may be taken, then
// it waits until the register is free. Reset clears every slot to type none,
// no candidate and never seen, and loads the registers with 3, 3, 3 and
// 500 ms. The APB port is to write the registers only while the block is
// idle; the block does not enforce it. pready is always high.
module device_type_confirm_qualifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [dtcq_pkg::SLOT_FIELD_W-1:0] slot,
  input  logic [1:0]                        seen_type,
  input  logic                              just_connected,
  input  logic [31:0]                       now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        held_type,
  output logic [1:0]                        candidate_type,
  output logic [15:0]                       candidate_count,
  output logic                              type_changed,
  output logic                              released,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dtcq_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import dtcq_pkg::*;

  dtcq_cmd_t cmd;

  assign pready = 1'b1;

  // Sequencing and handshakes.
  dtcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Slot state and registers.
  dtcq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .action          (action),
    .slot            (slot),
    .seen_type       (seen_type),
    .just_connected  (just_connected),
    .now_ms          (now_ms),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .held_type       (held_type),
    .candidate_type  (candidate_type),
    .candidate_count (candidate_count),
    .type_changed    (type_changed),
    .released        (released)
  );

  // A released slot reports type none, a change and no candidate.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && released |-> held_type == TYPE_NONE && type_changed &&
      candidate_type == TYPE_NONE && candidate_count == 16'd0)
    else $error("released result is inconsistent");

  // A taken item is worked on alone in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off while an item is in work");

  // A result is only loaded while the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_valid || !out_stall)
    else $error("result overwritten while stalled");

  // A commit always follows a capture and ends the work on that item.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !in_stall && out_valid)
    else $error("commit did not deliver a result");

endmodule
